// File: hw/rtl/linear_gradient_pixel_color_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_GRADIENT_PIXEL_COLOR_MACROS_SVH
`define LINEAR_GRADIENT_PIXEL_COLOR_MACROS_SVH

`ifndef SYNTHESIS
`define LGPC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lgpc: same-cycle check failed");
`define LGPC_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lgpc: next-cycle check failed");
`else
`define LGPC_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define LGPC_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: hw/rtl/lgpc_pkg.sv
// ----------------------------------------------------------------------------
// lgpc_pkg
// Types and constants of the linear gradient pixel color block.
// ----------------------------------------------------------------------------
package lgpc_pkg;

    localparam int COORD_WIDTH = 13;
    localparam int PIX_WIDTH   = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd5;

    typedef struct packed {
        logic [PIX_WIDTH-1:0] pixel_x;
        logic [PIX_WIDTH-1:0] pixel_y;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        drawn;
    } pix_out_t;

endpackage

// File: hw/rtl/linear_gradient_pixel_color.sv
// Pipeline: 14 register stages between the input transaction and out_valid.
// Throughput: one pixel per cycle while out_ready is high; every stage stalls alone,
// so bubbles close up. The 8-stage restoring divider forms each channel quotient.
// Async reset (rst_n low) empties the pipeline and clears the config registers to 0.
// ----------------------------------------------------------------------------
// linear_gradient_pixel_color
// Projects a pixel onto the anchor line and blends the two ARGB anchor colors.
// ----------------------------------------------------------------------------
`include "linear_gradient_pixel_color_macros.svh"

module linear_gradient_pixel_color (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lgpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lgpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lgpc_pkg::pix_in_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lgpc_pkg::pix_out_t                  out_data
);
    import lgpc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int PW   = ((CW > PIX_WIDTH) ? CW : PIX_WIDTH) + 2;
    localparam int DXW  = CW + 1;
    localparam int DW   = 2 * CW + 1;
    localparam int NW   = PW + DXW + 1;
    localparam int NUMW = DW + 9;
    localparam int NDIV = 8;
    localparam int NST  = 6 + NDIV;

    // configuration
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [31:0]          c1_reg, c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            y1_reg <= '0;
            x2_reg <= '0;
            y2_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:     x1_reg <= cfg_data[CW-1:0];
                REG_START_Y:     y1_reg <= cfg_data[CW-1:0];
                REG_END_X:       x2_reg <= cfg_data[CW-1:0];
                REG_END_Y:       y2_reg <= cfg_data[CW-1:0];
                REG_START_COLOR: c1_reg <= cfg_data[31:0];
                REG_END_COLOR:   c2_reg <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // flow control: each stage loads when it is empty or its successor loads
    logic [NST-1:0] v_reg;
    logic           rdy [NST+1];

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready = rdy[0];

    // stage 0: differences
    logic signed [PW-1:0]  pdx_reg, pdy_reg;
    logic signed [DXW-1:0] dx_reg, dy_reg;
    // stage 1: products
    logic signed [2*DXW-1:0]  dxx_reg, dyy_reg;
    logic signed [PW+DXW-1:0] ndx_reg, ndy_reg;
    // stage 2: dot products
    logic [DW-1:0]        d2_reg;
    logic signed [NW-1:0] n_reg;
    // stage 3: clamp
    logic [DW-1:0] nc_reg, dmn_reg, d3_reg;
    logic          dr3_reg;
    // stage 4: channel products
    logic [DW+7:0] pa_reg [4];
    logic [DW+7:0] pb_reg [4];
    logic [DW-1:0] d4_reg;
    logic          dr4_reg;
    // stage 5: numerators
    logic [NUMW-1:0] num_reg [4];
    logic [DW-1:0]   d5_reg;
    logic            dr5_reg;
    // divider stages
    logic [NUMW-1:0] rem_reg [NDIV][4];
    logic [7:0]      q_reg   [NDIV][4];
    logic [DW-1:0]   dd_reg  [NDIV];
    logic            dr_reg  [NDIV];

    logic [NUMW-1:0] rin [NDIV][4];
    logic [7:0]      qin [NDIV][4];
    logic [DW-1:0]   din [NDIV];
    logic            drin [NDIV];
    logic [NUMW-1:0] rem_next [NDIV][4];
    logic [7:0]      q_next   [NDIV][4];

    always_comb
    begin
        logic [NUMW-1:0] sub;
        for (int k = 0; k < NDIV; k++)
        begin
            if (k == 0)
            begin
                din[k]  = d5_reg;
                drin[k] = dr5_reg;
            end
            else
            begin
                din[k]  = dd_reg[k-1];
                drin[k] = dr_reg[k-1];
            end
            for (int ch = 0; ch < 4; ch++)
            begin
                if (k == 0)
                begin
                    rin[k][ch] = num_reg[ch];
                    qin[k][ch] = '0;
                end
                else
                begin
                    rin[k][ch] = rem_reg[k-1][ch];
                    qin[k][ch] = q_reg[k-1][ch];
                end
                sub = NUMW'(din[k]) << (NDIV - 1 - k);
                rem_next[k][ch] = rin[k][ch];
                q_next[k][ch]   = qin[k][ch];
                if (rin[k][ch] >= sub)
                begin
                    rem_next[k][ch] = rin[k][ch] - sub;
                    q_next[k][ch][NDIV-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pdx_reg <= $signed({{(PW-PIX_WIDTH){1'b0}}, in_data.pixel_x}) - PW'(x1_reg);
            pdy_reg <= $signed({{(PW-PIX_WIDTH){1'b0}}, in_data.pixel_y}) - PW'(y1_reg);
            dx_reg  <= DXW'(x2_reg) - DXW'(x1_reg);
            dy_reg  <= DXW'(y2_reg) - DXW'(y1_reg);
        end
        if (rdy[1])
        begin
            dxx_reg <= (2*DXW)'(dx_reg) * (2*DXW)'(dx_reg);
            dyy_reg <= (2*DXW)'(dy_reg) * (2*DXW)'(dy_reg);
            ndx_reg <= (PW+DXW)'(pdx_reg) * (PW+DXW)'(dx_reg);
            ndy_reg <= (PW+DXW)'(pdy_reg) * (PW+DXW)'(dy_reg);
        end
        if (rdy[2])
        begin
            d2_reg <= DW'(dxx_reg + dyy_reg);
            n_reg  <= NW'(ndx_reg) + NW'(ndy_reg);
        end
        if (rdy[3])
        begin
            // clamp the projection to [0, D]; the ends then divide out exactly
            if (n_reg[NW-1])
            begin
                nc_reg  <= '0;
                dmn_reg <= d2_reg;
            end
            else if (n_reg > $signed(NW'(d2_reg)))
            begin
                nc_reg  <= d2_reg;
                dmn_reg <= '0;
            end
            else
            begin
                nc_reg  <= DW'(n_reg);
                dmn_reg <= d2_reg - DW'(n_reg);
            end
            d3_reg  <= d2_reg;
            dr3_reg <= (d2_reg != '0);
        end
        if (rdy[4])
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                pa_reg[ch] <= (DW+8)'(c1_reg[8*ch +: 8]) * (DW+8)'(dmn_reg);
                pb_reg[ch] <= (DW+8)'(c2_reg[8*ch +: 8]) * (DW+8)'(nc_reg);
            end
            d4_reg  <= d3_reg;
            dr4_reg <= dr3_reg;
        end
        if (rdy[5])
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                num_reg[ch] <= NUMW'(pa_reg[ch]) + NUMW'(pb_reg[ch]);
            end
            d5_reg  <= d4_reg;
            dr5_reg <= dr4_reg;
        end
        for (int k = 0; k < NDIV; k++)
        begin
            if (rdy[6+k])
            begin
                for (int ch = 0; ch < 4; ch++)
                begin
                    rem_reg[k][ch] <= rem_next[k][ch];
                    q_reg[k][ch]   <= q_next[k][ch];
                end
                dd_reg[k] <= din[k];
                dr_reg[k] <= drin[k];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_data.drawn = dr_reg[NDIV-1];
    assign out_data.pixel_color = dr_reg[NDIV-1] ?
        {q_reg[NDIV-1][3], q_reg[NDIV-1][2], q_reg[NDIV-1][1], q_reg[NDIV-1][0]} : 32'd0;

    `LGPC_ASSERT_IMP(a_undrawn_black, clk, rst_n, out_valid && !out_data.drawn, out_data.pixel_color == 32'd0)
    `LGPC_ASSERT_IMP(a_clamp_in_range, clk, rst_n, v_reg[3], nc_reg <= d3_reg && dmn_reg == d3_reg - nc_reg)
    `LGPC_ASSERT_IMP(a_div_remainder, clk, rst_n, out_valid && out_data.drawn, rem_reg[NDIV-1][0] < NUMW'(dd_reg[NDIV-1]))
    `LGPC_ASSERT_IMP(a_stall_only_full, clk, rst_n, !in_ready, (&v_reg) && !out_ready)

endmodule

// File: test/linear_gradient_pixel_color_tb.sv
// ----------------------------------------------------------------------------
// linear_gradient_pixel_color_tb
// Streams pixel coordinates through the gradient block under several anchor
// and color settings, predicts each ARGB result in the bench and compares
// every output transaction in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module linear_gradient_pixel_color_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 200;

    typedef struct {
        int       setup;
        pix_in_t  pix;
        bit       known;
        pix_out_t want;
    } pixel_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pix_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    pix_out_t              out_data;

    logic signed [COORD_WIDTH-1:0] anchor_sx, anchor_sy, anchor_ex, anchor_ey;
    logic [31:0]                   color_start, color_end;

    pix_out_t pending_colors[$];
    int       mismatches;
    int       sender_idle_pct;
    int       receiver_idle_pct;
    bit       hold_off_request;
    int       hold_off_left;
    int       quiet_cycles;

    linear_gradient_pixel_color dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic pix_out_t predict_gradient(pix_in_t p);
        longint   x1, y1, dx, dy, d, n, num;
        logic [7:0] a, b;
        pix_out_t r;
        x1 = longint'(anchor_sx);
        y1 = longint'(anchor_sy);
        dx = longint'(anchor_ex) - x1;
        dy = longint'(anchor_ey) - y1;
        d  = dx * dx + dy * dy;
        r  = '0;
        if (d == 0)
            return r;
        n = (longint'(p.pixel_x) - x1) * dx + (longint'(p.pixel_y) - y1) * dy;
        r.drawn = 1'b1;
        if (n < 0)
            r.pixel_color = color_start;
        else if (n > d)
            r.pixel_color = color_end;
        else
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                a = color_start[ch*8 +: 8];
                b = color_end[ch*8 +: 8];
                num = longint'(a) * (d - n) + longint'(b) * n;
                r.pixel_color[ch*8 +: 8] = 8'(num / d);
            end
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_START_X:     anchor_sx   = value[COORD_WIDTH-1:0];
            REG_START_Y:     anchor_sy   = value[COORD_WIDTH-1:0];
            REG_END_X:       anchor_ex   = value[COORD_WIDTH-1:0];
            REG_END_Y:       anchor_ey   = value[COORD_WIDTH-1:0];
            REG_START_COLOR: color_start = value;
            REG_END_COLOR:   color_end   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Upper bits of coordinate writes are noise the block must drop.
    task automatic write_anchors(int sx, int sy, int ex, int ey, logic [31:0] c1,
                                 logic [31:0] c2);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_START_X, {junk[31:13], 13'(sx)});
        junk = $urandom;
        write_reg(REG_START_Y, {junk[31:13], 13'(sy)});
        junk = $urandom;
        write_reg(REG_END_X, {junk[31:13], 13'(ex)});
        junk = $urandom;
        write_reg(REG_END_Y, {junk[31:13], 13'(ey)});
        write_reg(REG_START_COLOR, c1);
        write_reg(REG_END_COLOR, c2);
        if ($urandom_range(1))
            write_reg(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(pix_in_t p);
        // idle cycle by cycle before offering the next transaction
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_colors.push_back(predict_gradient(p));
    endtask

    function automatic int pick_coord();
        case ($urandom_range(9))
            0:       return -4096;
            1:       return 4095;
            2:       return $urandom_range(8191) - 4096;
            default: return $urandom_range(4095);
        endcase
    endfunction

    task automatic random_setup();
        int sx, sy, ex, ey;
        sx = pick_coord();
        sy = pick_coord();
        if ($urandom_range(15) == 0)
        begin
            ex = sx;
            ey = sy;
        end
        else
        begin
            ex = pick_coord();
            ey = pick_coord();
        end
        write_anchors(sx, sy, ex, ey, $urandom, $urandom);
    endtask

    // Output checker
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("%0t: unexpected output color=%08h drawn=%0b", $time,
                         out_data.pixel_color, out_data.drawn);
                mismatches++;
            end
            else
            begin
                want = pending_colors.pop_front();
                if (out_data.pixel_color !== want.pixel_color)
                begin
                    $display("%0t: pixel_color expected %08h actual %08h", $time,
                             want.pixel_color, out_data.pixel_color);
                    mismatches++;
                end
                if (out_data.drawn !== want.drawn)
                begin
                    $display("%0t: drawn expected %0b actual %0b", $time,
                             want.drawn, out_data.drawn);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random backpressure, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_request)
        begin
            hold_off_request = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    pixel_row_t directed_rows[] = '{
        // coincident anchors after reset
        '{0, '{12'd0,    12'd0},    1'b1, '{32'h0000_0000, 1'b0}},
        '{0, '{12'd4095, 12'd4095}, 1'b1, '{32'h0000_0000, 1'b0}},
        '{0, '{12'd2048, 12'd7},    1'b1, '{32'h0000_0000, 1'b0}},
        // (100,0) to (355,0): before, at ends, between, beyond
        '{1, '{12'd0,    12'd0},    1'b1, '{32'hFF00_FF00, 1'b1}},
        '{1, '{12'd100,  12'd4095}, 1'b1, '{32'hFF00_FF00, 1'b1}},
        '{1, '{12'd355,  12'd0},    1'b1, '{32'h00FF_00FF, 1'b1}},
        '{1, '{12'd4095, 12'd4095}, 1'b1, '{32'h00FF_00FF, 1'b1}},
        '{1, '{12'd101,  12'd0},    1'b0, '{32'h0, 1'b0}},
        '{1, '{12'd227,  12'd99},   1'b0, '{32'h0, 1'b0}},
        '{1, '{12'd354,  12'd0},    1'b0, '{32'h0, 1'b0}},
        // extreme anchors across the whole coordinate range
        '{2, '{12'd0,    12'd0},    1'b0, '{32'h0, 1'b0}},
        '{2, '{12'd4095, 12'd4095}, 1'b0, '{32'h0, 1'b0}},
        '{2, '{12'd4095, 12'd0},    1'b0, '{32'h0, 1'b0}},
        '{2, '{12'd1234, 12'd3001}, 1'b0, '{32'h0, 1'b0}},
        // descending anchors
        '{3, '{12'd300,  12'd200},  1'b0, '{32'h0, 1'b0}},
        '{3, '{12'd50,   12'd200},  1'b0, '{32'h0, 1'b0}},
        '{3, '{12'd175,  12'd3},    1'b0, '{32'h0, 1'b0}},
        '{3, '{12'd10,   12'd0},    1'b0, '{32'h0, 1'b0}},
        '{3, '{12'd2000, 12'd0},    1'b0, '{32'h0, 1'b0}}
    };

    initial
    begin
        int       setup;
        pix_in_t  p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        mismatches = 0;
        sender_idle_pct = 26;
        receiver_idle_pct = 59;
        hold_off_request = 1'b0;
        hold_off_left = 0;
        quiet_cycles = 0;
        anchor_sx = '0;
        anchor_sy = '0;
        anchor_ex = '0;
        anchor_ey = '0;
        color_start = '0;
        color_end = '0;
        setup = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].setup != setup)
            begin
                wait_drained();
                setup = directed_rows[i].setup;
                case (setup)
                    1: write_anchors(100, 0, 355, 0, 32'hFF00_FF00, 32'h00FF_00FF);
                    2: write_anchors(-4096, -4096, 4095, 4095, 32'hFFFF_FFFF, 32'h0);
                    default: write_anchors(300, 200, 50, 200, 32'h1234_5678, 32'hFEDC_BA98);
                endcase
            end
            send_pixel(directed_rows[i].pix);
            if (directed_rows[i].known)
                pending_colors[pending_colors.size()-1] = directed_rows[i].want;
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct   = (phase == 0) ? 26 : (phase == 1) ? 59 : 0;
            receiver_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 26 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                wait_drained();
                random_setup();
                if (phase == 2 && blk == 0)
                    hold_off_request = 1'b1;
                for (int k = 0; k < 52; k++)
                begin
                    p.pixel_x = PIX_WIDTH'($urandom);
                    p.pixel_y = PIX_WIDTH'($urandom);
                    send_pixel(p);
                end
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
